// ===== design/pmt_pkg.sv =====
// Shared types and constants for the program map section parser.
// Depends on nothing; every design file imports it.
package pmt_pkg;

    // largest number of elementary stream entries kept per section
    localparam int unsigned MAX_STREAMS = 32;

    localparam logic [7:0]  PMT_TID = 8'h02;
    localparam logic [12:0] OFS_MAX      = 13'h1FFF;
    // offset of the first byte past the fixed header
    localparam logic [12:0] OFS_FIRST_ENTRY = 13'd12;

    // kind of result record
    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_ENTRY  = 2'd1,
        REC_DONE   = 2'd2,
        REC_ERROR  = 2'd3
    } rec_kind_t;

    // error code of an error record
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_TID  = 2'd1,
        ERR_TOO_MANY = 2'd2
    } err_code_t;

    // parser phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_WAIT   = 2'd2,
        PH_ENTRY  = 2'd3
    } phase_t;

    // one section byte beat
    typedef struct packed {
        logic [7:0] byte_value;
        logic       section_start;
    } sec_beat_t;

    // one result record beat
    typedef struct packed {
        rec_kind_t   record_kind;
        err_code_t   error_code;
        logic [15:0] prog_number;
        logic [4:0]  version_number;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic [12:0] clock_ref_pid;
        logic [11:0] info_length;
        logic [7:0]  strm_type;
        logic [12:0] strm_pid;
        logic [7:0]  stream_count;
    } rec_beat_t;

    // handshake between the input stage and the parse core
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== design/pmt_in_stage.sv =====
// Input register for section byte beats with stall back to the source.
// Depends on pmt_pkg.
module pmt_in_stage
    import pmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sec_valid,
    output logic       sec_stall,
    input  sec_beat_t  sec_beat,
    output stage_ctl_t ctl,
    input  logic       advance,
    output sec_beat_t  beat
);

    logic      valid_reg;
    sec_beat_t beat_reg;

    // hold the beat while the parse core cannot take it
    assign sec_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!sec_stall)
        begin
            valid_reg <= sec_valid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (sec_valid && !sec_stall)
        begin
            beat_reg <= sec_beat;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign beat        = beat_reg;

endmodule

// ===== design/pmt_parse_core.sv =====
// Parser state and the per-byte decode that forms header, entry, done and error records.
// Depends on pmt_pkg.
module pmt_parse_core
    import pmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  sec_beat_t  beat,
    output logic       rec_hit,
    output rec_beat_t  rec
);

    // byte offsets inside the fixed header
    localparam logic [12:0] OFS_LEN_HI  = 13'd1;
    localparam logic [12:0] OFS_LEN_LO  = 13'd2;
    localparam logic [12:0] OFS_PROG_HI = 13'd3;
    localparam logic [12:0] OFS_PROG_LO = 13'd4;
    localparam logic [12:0] OFS_VER     = 13'd5;
    localparam logic [12:0] OFS_SEC     = 13'd6;
    localparam logic [12:0] OFS_LAST    = 13'd7;
    localparam logic [12:0] OFS_PCR_HI  = 13'd8;
    localparam logic [12:0] OFS_PCR_LO  = 13'd9;
    localparam logic [12:0] OFS_PIL_HI  = 13'd10;

    // entry byte positions after the stream type byte
    localparam logic [1:0] ENT_PID_HI  = 2'd0;
    localparam logic [1:0] ENT_PID_LO  = 2'd1;
    localparam logic [1:0] ENT_ESIL_HI = 2'd2;
    localparam logic [1:0] ENT_ESIL_LO = 2'd3;

    phase_t      phase_reg, phase_next;
    logic [12:0] offset_reg, offset_next;
    logic [11:0] sec_len_reg, sec_len_next;
    logic [3:0]  pil_hi_reg, pil_hi_next;
    logic [15:0] prog_reg, prog_next;
    logic [4:0]  ver_reg, ver_next;
    logic        cn_reg, cn_next;
    logic [7:0]  sec_reg, sec_next;
    logic [7:0]  last_reg, last_next;
    logic [12:0] pcr_reg, pcr_next;
    logic [1:0]  ent_idx_reg, ent_idx_next;
    logic [7:0]  type_reg, type_next;
    logic [12:0] pid_reg, pid_next;
    logic [3:0]  esil_hi_reg, esil_hi_next;
    logic [12:0] next_ofs_reg, next_ofs_next;
    logic [7:0]  count_reg, count_next;

    logic        go;
    logic [7:0]  b;
    logic        start;
    logic        bad_id;
    logic [12:0] offset_inc;
    logic        at_boundary;
    logic        at_crc;
    logic        store_full;
    logic        hdr_last;
    logic        ent_last;
    logic [11:0] pil_full;
    logic [11:0] esil_full;
    logic [13:0] ent_end;
    logic [12:0] ent_end_sat;

    // shared decode
    assign go          = ctl.valid && ctl.advance;
    assign b           = beat.byte_value;
    assign start       = beat.section_start;
    assign bad_id      = (b != PMT_TID);
    assign offset_inc  = (offset_reg == OFS_MAX) ? OFS_MAX : offset_reg + 13'd1;
    assign at_boundary = (offset_reg == next_ofs_reg);
    assign at_crc      = ({1'b0, offset_reg} + 14'd1) >= {2'b00, sec_len_reg};
    assign store_full  = ({24'd0, count_reg} >= MAX_STREAMS);
    assign hdr_last    = (phase_reg == PH_HEADER) && (offset_reg > OFS_PIL_HI);
    assign ent_last    = (phase_reg == PH_ENTRY) && (ent_idx_reg == ENT_ESIL_LO);
    assign pil_full    = {pil_hi_reg, b};
    assign esil_full   = {esil_hi_reg, b};
    assign ent_end     = {1'b0, offset_reg} + 14'd1 + {2'b00, esil_full};
    assign ent_end_sat = ent_end[13] ? OFS_MAX : ent_end[12:0];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
        begin
            phase_next = bad_id ? PH_IDLE : PH_HEADER;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:   phase_next = PH_IDLE;
                PH_HEADER: phase_next = hdr_last ? PH_WAIT : PH_HEADER;
                PH_WAIT:
                begin
                    if (at_boundary)
                    begin
                        phase_next = (at_crc || store_full) ? PH_IDLE : PH_ENTRY;
                    end
                end
                PH_ENTRY:  phase_next = ent_last ? PH_WAIT : PH_ENTRY;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    // field capture and counters
    always_comb
    begin
        offset_next   = offset_reg;
        sec_len_next  = sec_len_reg;
        pil_hi_next   = pil_hi_reg;
        prog_next     = prog_reg;
        ver_next      = ver_reg;
        cn_next       = cn_reg;
        sec_next      = sec_reg;
        last_next     = last_reg;
        pcr_next      = pcr_reg;
        ent_idx_next  = ent_idx_reg;
        type_next     = type_reg;
        pid_next      = pid_reg;
        esil_hi_next  = esil_hi_reg;
        next_ofs_next = next_ofs_reg;
        count_next    = count_reg;
        if (start)
        begin
            offset_next   = 13'd1;
            sec_len_next  = 12'd0;
            ent_idx_next  = ENT_PID_HI;
            next_ofs_next = 13'd0;
            count_next    = 8'd0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            offset_next = offset_inc;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (offset_reg)
                        OFS_LEN_HI:  sec_len_next = {b[3:0], 8'd0};
                        OFS_LEN_LO:  sec_len_next = {sec_len_reg[11:8], b};
                        OFS_PROG_HI: prog_next = {b, prog_reg[7:0]};
                        OFS_PROG_LO: prog_next = {prog_reg[15:8], b};
                        OFS_VER:
                        begin
                            ver_next = b[5:1];
                            cn_next  = b[0];
                        end
                        OFS_SEC:     sec_next = b;
                        OFS_LAST:    last_next = b;
                        OFS_PCR_HI:  pcr_next = {b[4:0], pcr_reg[7:0]};
                        OFS_PCR_LO:  pcr_next = {pcr_reg[12:8], b};
                        OFS_PIL_HI:  pil_hi_next = b[3:0];
                        default:     next_ofs_next = OFS_FIRST_ENTRY + {1'b0, pil_full};
                    endcase
                end
                PH_WAIT:
                begin
                    if (at_boundary && !at_crc && !store_full)
                    begin
                        type_next    = b;
                        ent_idx_next = ENT_PID_HI;
                    end
                end
                PH_ENTRY:
                begin
                    ent_idx_next = ent_idx_reg + 2'd1;
                    unique case (ent_idx_reg)
                        ENT_PID_HI:  pid_next = {b[4:0], pid_reg[7:0]};
                        ENT_PID_LO:  pid_next = {pid_reg[12:8], b};
                        ENT_ESIL_HI: esil_hi_next = b[3:0];
                        ENT_ESIL_LO:
                        begin
                            count_next    = count_reg + 8'd1;
                            next_ofs_next = ent_end_sat;
                        end
                        default:     ent_idx_next = ENT_PID_HI;
                    endcase
                end
                default:
                begin
                    offset_next = offset_reg;
                end
            endcase
        end
    end

    // record forming
    always_comb
    begin
        rec_hit = 1'b0;
        rec     = '0;
        if (start)
        begin
            if (bad_id)
            begin
                rec_hit         = 1'b1;
                rec.record_kind = REC_ERROR;
                rec.error_code  = ERR_BAD_TID;
            end
        end
        else if (hdr_last)
        begin
            rec_hit                = 1'b1;
            rec.record_kind        = REC_HEADER;
            rec.prog_number        = prog_reg;
            rec.version_number     = ver_reg;
            rec.current_next       = cn_reg;
            rec.section_index      = sec_reg;
            rec.last_section_index = last_reg;
            rec.clock_ref_pid      = pcr_reg;
            rec.info_length        = pil_full;
        end
        else if (ent_last)
        begin
            rec_hit          = 1'b1;
            rec.record_kind  = REC_ENTRY;
            rec.info_length  = esil_full;
            rec.strm_type    = type_reg;
            rec.strm_pid     = pid_reg;
            rec.stream_count = count_reg;
        end
        else if (phase_reg == PH_WAIT && at_boundary)
        begin
            if (at_crc)
            begin
                rec_hit          = 1'b1;
                rec.record_kind  = REC_DONE;
                rec.stream_count = count_reg;
            end
            else if (store_full)
            begin
                rec_hit          = 1'b1;
                rec.record_kind  = REC_ERROR;
                rec.error_code   = ERR_TOO_MANY;
                rec.stream_count = count_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            offset_reg   <= 13'd0;
            sec_len_reg  <= 12'd0;
            ent_idx_reg  <= ENT_PID_HI;
            next_ofs_reg <= 13'd0;
            count_reg    <= 8'd0;
        end
        else if (go)
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            sec_len_reg  <= sec_len_next;
            ent_idx_reg  <= ent_idx_next;
            next_ofs_reg <= next_ofs_next;
            count_reg    <= count_next;
        end
    end

    // held payload fields
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pil_hi_reg  <= pil_hi_next;
            prog_reg    <= prog_next;
            ver_reg     <= ver_next;
            cn_reg      <= cn_next;
            sec_reg     <= sec_next;
            last_reg    <= last_next;
            pcr_reg     <= pcr_next;
            type_reg    <= type_next;
            pid_reg     <= pid_next;
            esil_hi_reg <= esil_hi_next;
        end
    end

endmodule

// ===== design/pmt_section_parser.sv =====
// Program map section parser, top level: input stage, parse core and result register.
// Depends on pmt_pkg, pmt_in_stage and pmt_parse_core.
//
// Takes one section byte per beat and gives at most one record per byte: a header
// record on byte 11, one record on the fifth byte of each elementary stream entry,
// a done record with the entry count at the first entry boundary at or past the CRC,
// and an error record for a wrong table id or for more than MAX_STREAMS entries.
// A byte marked section_start always opens a new section. The block takes one byte
// every cycle while sec_stall is low; a byte enters the input register, is decoded
// there against the parser state, and its record is loaded into the result register
// when the byte advances, so each record passes both registers in order.
// The result register is the only buffer on the output side: while it holds a stalled
// record, bytes that give no record keep flowing and the first byte that does give
// one waits.
module pmt_section_parser
    import pmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sec_valid,
    output logic      sec_stall,
    input  sec_beat_t sec_beat,
    output logic      rec_valid,
    input  logic      rec_stall,
    output rec_beat_t rec_beat
);

    stage_ctl_t ctl;
    sec_beat_t  core_beat;
    logic       advance;
    logic       rec_hit;
    rec_beat_t  core_rec;
    logic       out_valid_reg;
    rec_beat_t  out_beat_reg;
    logic       out_free;

    // output side can take a new beat
    assign out_free = !out_valid_reg || !rec_stall;
    assign advance  = ctl.valid && (out_free || !rec_hit);

    pmt_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .sec_valid (sec_valid),
        .sec_stall (sec_stall),
        .sec_beat  (sec_beat),
        .ctl       (ctl),
        .advance   (advance),
        .beat      (core_beat)
    );

    pmt_parse_core u_parse_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .beat    (core_beat),
        .rec_hit (rec_hit),
        .rec     (core_rec)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && rec_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && rec_hit)
        begin
            out_beat_reg <= core_rec;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_beat  = out_beat_reg;

    // a stalled record is never overwritten by a new one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_stall && ctl.valid && rec_hit) |-> !advance)
        else $error("record produced while result register is blocked");

    // input side stalls only while a byte is held and cannot move
    assert property (@(posedge clk) disable iff (!rst_n)
        sec_stall |-> (ctl.valid && out_valid_reg && rec_stall && rec_hit))
        else $error("input stalled without a blocked record");

    // a new record appears only after a byte that produced one
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && !$past(rec_valid && rec_stall)) |-> $past(advance && rec_hit))
        else $error("record without a source byte");

    // every non-error record carries the error code ERR_NONE
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_beat.record_kind != REC_ERROR)
            |-> (rec_beat.error_code == ERR_NONE))
        else $error("error code on a non-error record");

endmodule
